### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the timer queue.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MHTQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MHTQ_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MHTQ_ASSERT(lbl, clk, rst, prop, msg)
`define MHTQ_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/mhtq_pkg.sv
// Package for the min-heap timer queue: payload structs, codes, constants.
// No dependencies.
package mhtq_pkg;

   localparam int CapacityDefault = 32;
   localparam int MaxResults      = 32;
   localparam int PopCountWidth   = $clog2(MaxResults + 1);

   localparam logic [2:0] StatusAdded   = 3'd0;
   localparam logic [2:0] StatusExpired = 3'd1;
   localparam logic [2:0] StatusNone    = 3'd2;
   localparam logic [2:0] StatusFull    = 3'd3;
   localparam logic [2:0] StatusBadTime = 3'd4;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_TICK,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic        cmd;
      logic [15:0] timeout;
      logic [15:0] timer_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] expired_id;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] timeout;
      logic [15:0] timer_id;
   } work_type;

   typedef struct packed {
      logic [31:0] expiry;
      logic [15:0] id;
   } heap_entry_type;

   // a is before b when the wrapped difference is negative
   function automatic logic is_before(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

endpackage

### rtl/core/mhtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhtq_ram #(
   parameter int Width = 48,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/mhtq_front.sv
// Front end: accept requests, classify them, hold them in a two-entry queue.
// Depends on mhtq_pkg.
module mhtq_front import mhtq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   output logic     work_valid,
   output work_type work_item,
   input  logic     work_take
);
   work_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;
   work_type   cls;
   logic       push, pop;

   always_comb begin
      cls.timeout  = req_payload.timeout;
      cls.timer_id = req_payload.timer_id;
      if (req_payload.cmd) begin
         cls.op = OP_TICK;
      end else if (req_payload.timeout == 16'd0) begin
         cls.op = OP_BAD;
      end else begin
         cls.op = OP_ADD;
      end
   end

   assign req_stall  = (fill_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign work_valid = (fill_ff != 2'd0);
   assign pop        = work_valid && work_take;
   assign work_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

### rtl/core/mhtq_back.sv
// Back end: heap engine that runs sift-up on add and pop/sift-down on tick.
// Depends on mhtq_pkg and mhtq_ram.
module mhtq_back import mhtq_pkg::*; #(
   parameter int Capacity = CapacityDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     work_valid,
   input  work_type work_item,
   output logic     work_take,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload,
   output logic [$clog2(Capacity+1)-1:0] entry_count
);
   localparam int AW = $clog2(Capacity);
   localparam int CW = $clog2(Capacity + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_UP_TOP, S_UP_CHK, S_RESULT, S_TK_TOP, S_TK_CHK,
      S_POP_WAIT, S_DN_TOP, S_DN_L, S_DN_R, S_TK_DONE
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [31:0]    time_ff, time_in;
   logic [AW-1:0]  hole_ff, hole_in;
   logic [AW-1:0]  kid_ff, kid_in;
   heap_entry_type mov_ff, mov_in;
   heap_entry_type left_ff, left_in;
   logic [2:0]     res_ff, res_in;
   logic [PopCountWidth-1:0] pops_ff, pops_in;
   logic           pend_ff, pend_in;
   logic [15:0]    pend_id_ff, pend_id_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;

   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   heap_entry_type wr_data, rd_data;
   logic           out_free;
   logic [AW+1:0]  kid_w;
   logic [AW-1:0]  hole_m1;
   logic [CW-1:0]  count_m1;
   heap_entry_type chosen;
   logic [AW-1:0]  chosen_idx;
   logic           go_right;

   mhtq_ram #(.Width($bits(heap_entry_type)), .Depth(Capacity)) u_heap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign kid_w       = {1'b0, hole_ff, 1'b1};
   assign hole_m1     = hole_ff - 1'b1;
   assign count_m1    = count_ff - 1'b1;
   assign go_right    = (state_ff == S_DN_R) && is_before(rd_data.expiry, left_ff.expiry);
   assign chosen      = (state_ff == S_DN_R) ? (go_right ? rd_data : left_ff) : rd_data;
   assign chosen_idx  = go_right ? kid_ff + 1'b1 : kid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign entry_count = count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      hole_in      = hole_ff;
      kid_in       = kid_ff;
      mov_in       = mov_ff;
      left_in      = left_ff;
      res_in       = res_ff;
      pops_in      = pops_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      wr_en        = 1'b0;
      wr_addr      = hole_ff;
      wr_data      = mov_ff;
      rd_en        = 1'b0;
      rd_addr      = hole_ff;
      work_take    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (work_valid) begin
               work_take = 1'b1;
               unique case (work_item.op)
                  OP_BAD: begin
                     res_in   = StatusBadTime;
                     state_in = S_RESULT;
                  end
                  OP_ADD: begin
                     if (count_ff >= CW'(Capacity)) begin
                        res_in   = StatusFull;
                        state_in = S_RESULT;
                     end else begin
                        mov_in.expiry = time_ff + {16'd0, work_item.timeout};
                        mov_in.id     = work_item.timer_id;
                        hole_in       = count_ff[AW-1:0];
                        count_in      = count_ff + 1'b1;
                        state_in      = S_UP_TOP;
                     end
                  end
                  default: begin
                     time_in  = time_ff + 32'd1;
                     pops_in  = '0;
                     pend_in  = 1'b0;
                     state_in = S_TK_TOP;
                  end
               endcase
            end
         end
         S_UP_TOP: begin
            if (hole_ff == '0) begin
               wr_en    = 1'b1;
               res_in   = StatusAdded;
               state_in = S_RESULT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = hole_m1 >> 1;
               kid_in   = hole_m1 >> 1;
               state_in = S_UP_CHK;
            end
         end
         S_UP_CHK: begin
            wr_en = 1'b1;
            if (is_before(mov_ff.expiry, rd_data.expiry)) begin
               wr_data  = rd_data;
               hole_in  = kid_ff;
               state_in = S_UP_TOP;
            end else begin
               res_in   = StatusAdded;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               out_in.status     = res_ff;
               out_in.expired_id = 16'd0;
               out_in.last       = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_TK_TOP: begin
            if (pops_ff == PopCountWidth'(MaxResults) || count_ff == '0) begin
               state_in = S_TK_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = S_TK_CHK;
            end
         end
         S_TK_CHK: begin
            if (is_before(time_ff, rd_data.expiry)) begin
               state_in = S_TK_DONE;
            end else if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  out_valid_in      = 1'b1;
                  out_in.status     = StatusExpired;
                  out_in.expired_id = pend_id_ff;
                  out_in.last       = 1'b0;
               end
               pend_in    = 1'b1;
               pend_id_in = rd_data.id;
               pops_in    = pops_ff + 1'b1;
               count_in   = count_m1;
               rd_en      = 1'b1;
               rd_addr    = count_m1[AW-1:0];
               state_in   = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            mov_in   = rd_data;
            hole_in  = '0;
            state_in = S_DN_TOP;
         end
         S_DN_TOP: begin
            if (kid_w >= (AW+2)'(count_ff)) begin
               wr_en    = 1'b1;
               state_in = S_TK_TOP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = kid_w[AW-1:0];
               kid_in   = kid_w[AW-1:0];
               state_in = S_DN_L;
            end
         end
         S_DN_L, S_DN_R: begin
            if (state_ff == S_DN_L && ((AW+2)'(kid_ff) + 1'b1) < (AW+2)'(count_ff)) begin
               left_in  = rd_data;
               rd_en    = 1'b1;
               rd_addr  = kid_ff + 1'b1;
               state_in = S_DN_R;
            end else begin
               wr_en = 1'b1;
               if (is_before(chosen.expiry, mov_ff.expiry)) begin
                  wr_data  = chosen;
                  hole_in  = chosen_idx;
                  state_in = S_DN_TOP;
               end else begin
                  state_in = S_TK_TOP;
               end
            end
         end
         S_TK_DONE: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               out_in.status     = pend_ff ? StatusExpired : StatusNone;
               out_in.expired_id = pend_ff ? pend_id_ff : 16'd0;
               out_in.last       = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      hole_ff    <= hole_in;
      kid_ff     <= kid_in;
      mov_ff     <= mov_in;
      left_ff    <= left_in;
      res_ff     <= res_in;
      pops_ff    <= pops_in;
      pend_id_ff <= pend_id_in;
      out_ff     <= out_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         time_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

### rtl/core/min_heap_timer_queue_unit.sv
// Timer queue as a binary min-heap. Add: sift-up, one parent read and compare
// per heap level climbed. Tick: for each pop, read and test the root, read the
// last entry, then sift down, reading the left and right child per level; the
// single-read heap RAM sets this order of steps. One request in work at a time;
// a two-entry front queue and an output register decouple both sides.
// Synchronous active-high reset empties the heap and clears the time counter.
module min_heap_timer_queue_unit import mhtq_pkg::*; #(
   parameter int Capacity = CapacityDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);
`include "assert_macros.svh"

   localparam int CW = $clog2(Capacity + 1);

   logic     work_valid, work_take;
   work_type work_item;
   logic [CW-1:0] entry_count;

   // Classify each request and hold it until the heap engine is free.
   mhtq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .work_valid  (work_valid),
      .work_item   (work_item),
      .work_take   (work_take)
   );

   // Heap engine: sift-up on add, pop and sift-down on tick.
   mhtq_back #(.Capacity(Capacity)) u_back (
      .clock       (clock),
      .reset       (reset),
      .work_valid  (work_valid),
      .work_item   (work_item),
      .work_take   (work_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .entry_count (entry_count)
   );

   `MHTQ_ASSERT(a_count_bound, clock, reset, entry_count <= CW'(Capacity), "count over capacity")
   `MHTQ_ASSERT(a_id_zero, clock, reset, (rsp_valid && rsp_payload.status != StatusExpired) |-> (rsp_payload.expired_id == 16'd0), "id set")
   `MHTQ_ASSERT(a_single_last, clock, reset, (rsp_valid && rsp_payload.status != StatusExpired) |-> rsp_payload.last, "no last")
endmodule
